FILE: rtl/cloud_in_cell_deposit_core_assert.svh
// Assertion macros for the cloud-in-cell deposit core.
// Macro bodies are empty when SYNTHESIS is defined.
`ifndef CLOUD_IN_CELL_DEPOSIT_CORE_ASSERT_SVH
`define CLOUD_IN_CELL_DEPOSIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CIC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define CIC_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define CIC_ASSERT(label, clk, rst, prop)
`define CIC_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: rtl/cic_pkg.sv
// Shared types and constants for the cloud-in-cell deposit core.
// No dependencies.
`default_nettype none
package cic_pkg;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned IndexWidth = 18;
   localparam logic CsrInvCellSize   = 1'b0;
   localparam logic CsrParticleWeight = 1'b1;
   localparam logic ModeDeposit = 1'b0;
   localparam logic ModeRead    = 1'b1;

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_SCALE   = 9'b000000100,
      ST_SPLIT   = 9'b000001000,
      ST_W1      = 9'b000010000,
      ST_W2      = 9'b000100000,
      ST_W3      = 9'b001000000,
      ST_RMW     = 9'b010000000,
      ST_RESP    = 9'b100000000
   } state_type;

   typedef struct packed {
      logic clear_step;   // write zero at clear address, advance it
      logic load;         // capture request
      logic scale;        // multiply positions by inverse cell size
      logic split;        // cell and weights per axis
      logic wmul;         // one step of weight product
      logic rd;           // read memory at current corner / read index
      logic wr;           // write back accumulated value
      logic corner_next;  // advance corner counter
      logic [1:0] wstep;  // which axis factor multiplies in
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic last_corner;
      logic is_read;
   } status_type;
endpackage
`default_nettype wire

FILE: rtl/cic_datapath.sv
// Datapath: scaling, axis split, weight products and the density memory.
// Depends on cic_pkg.
`default_nettype none
module cic_datapath #(
   parameter int unsigned GRID = 64,
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire cic_pkg::cmd_type cmd,
   output      cic_pkg::status_type status,
   input  wire logic req_mode,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [17:0] req_read_index,
   input  wire logic [31:0] inv_cell_size,
   input  wire logic [31:0] particle_weight,
   output      logic [17:0] rsp_cell_index,
   output      logic [31:0] rsp_cell_value
);
   localparam int unsigned CW    = $clog2(GRID);
   localparam int unsigned CELLS = GRID * GRID * GRID;
   localparam int unsigned AW    = $clog2(CELLS);
   localparam int unsigned UW    = 64 - FRAC_BITS;
   localparam int unsigned FW    = FRAC_BITS + 1;

   logic [31:0] mem [CELLS];
   logic [31:0] rdata_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic mode_ff;
   logic [31:0] pos_ff [3];
   logic [17:0] ridx_ff;
   logic [UW-1:0] u_ff [3];
   logic [CW-1:0] home_ff [3];
   logic [CW-1:0] nbr_ff [3];
   logic [FW-1:0] wh_ff [3];
   logic [FW-1:0] wn_ff [3];
   logic [2:0] corner_ff;
   logic [31:0] w_ff, w_in;
   logic [31:0] wcorner_ff [8];
   logic [AW-1:0] addr_ff;
   logic addr_ok_ff;
   logic rd_valid_ff;
   logic [AW-1:0] addr_in;
   logic [2:0] cq;

   assign status.clear_done  = (clr_ff == AW'(CELLS - 1));
   assign status.last_corner = (corner_ff == 3'd7);
   assign status.is_read     = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_in;
   end
   assign clr_in = clr_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
         ridx_ff <= req_read_index;
      end
   end

   // Scale to cell units; one 32x32 product per axis.
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         for (int a = 0; a < 3; a++) begin
            u_ff[a] <= UW'(({32'd0, pos_ff[a]} * {32'd0, inv_cell_size}) >> FRAC_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.split) begin
         for (int a = 0; a < 3; a++) begin
            logic [UW-1:0] c, centre, d;
            logic up;
            c = u_ff[a] >> FRAC_BITS;
            if (c > UW'(GRID - 1)) c = UW'(GRID - 1);
            centre = (c << FRAC_BITS) + (UW'(1) << (FRAC_BITS - 1));
            up = (u_ff[a] >= centre);
            d = up ? (u_ff[a] - centre) : (centre - u_ff[a]);
            if (d > (UW'(1) << FRAC_BITS)) d = UW'(1) << FRAC_BITS;
            home_ff[a] <= c[CW-1:0];
            if (up) nbr_ff[a] <= (c == UW'(GRID - 1)) ? '0 : CW'(c + UW'(1));
            else    nbr_ff[a] <= (c == '0) ? CW'(GRID - 1) : CW'(c - UW'(1));
            wn_ff[a] <= d[FW-1:0];
            wh_ff[a] <= FW'((UW'(1) << FRAC_BITS) - d);
         end
      end
   end

   // Weight products: x factor, then y, then z, for all eight corners in lanes.
   always_ff @(posedge clock) begin
      if (cmd.wmul) begin
         for (int k = 0; k < 8; k++) begin
            logic [31:0] base;
            logic [FW-1:0] f;
            logic [63:0] p;
            case (cmd.wstep)
               2'd0: begin base = particle_weight; f = k[2] ? wn_ff[0] : wh_ff[0]; end
               2'd1: begin base = wcorner_ff[k];   f = k[1] ? wn_ff[1] : wh_ff[1]; end
               default: begin base = wcorner_ff[k]; f = k[0] ? wn_ff[2] : wh_ff[2]; end
            endcase
            p = ({32'd0, base} * 64'(f)) >> FRAC_BITS;
            wcorner_ff[k] <= p[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.split) corner_ff <= '0;
      else if (cmd.corner_next) corner_ff <= corner_ff + 3'd1;
   end
   assign cq = corner_ff;

   // flat index x*GRID*GRID + y*GRID + z of the current corner, or the read index in read mode
   always_comb begin
      addr_in = (AW'(cq[2] ? nbr_ff[0] : home_ff[0]) * AW'(GRID)
                 + AW'(cq[1] ? nbr_ff[1] : home_ff[1])) * AW'(GRID)
                + AW'(cq[0] ? nbr_ff[2] : home_ff[2]);
      if (mode_ff) addr_in = AW'(ridx_ff);
   end

   // Read stage: register address and data; write stage uses them.
   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else rd_valid_ff <= cmd.rd;
      if (cmd.rd) begin
         addr_ff <= addr_in;
         addr_ok_ff <= !mode_ff || ({14'd0, ridx_ff} < 32'(CELLS));
         rdata_ff <= mem[addr_in];
         w_ff <= wcorner_ff[cq];
      end
   end

   logic [32:0] sum;
   assign sum = {1'b0, rdata_ff} + {1'b0, w_ff};
   always_comb w_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem[clr_ff] <= '0;
      else if (rd_valid_ff && addr_ok_ff) mem[addr_ff] <= mode_ff ? 32'd0 : w_in;
   end

   assign rsp_cell_index = ridx_ff;
   assign rsp_cell_value = addr_ok_ff ? rdata_ff : 32'd0;
endmodule
`default_nettype wire

FILE: rtl/cic_control.sv
// Controller state machine for the cloud-in-cell deposit core.
// Depends on cic_pkg and the assertion macro header.
`default_nettype none
`include "cloud_in_cell_deposit_core_assert.svh"
module cic_control (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output      logic req_ready,
   output      logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire cic_pkg::status_type status,
   output      cic_pkg::cmd_type cmd
);
   cic_pkg::state_type state_ff, state_in;
   logic rmw_ph_ff, rmw_ph_in; // 0 read phase, 1 write phase in ST_RMW; in ST_RESP, 1 once rsp_valid is up

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cic_pkg::ST_CLEAR;
         rmw_ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rmw_ph_ff <= rmw_ph_in;
      end
   end

   assign req_ready = (state_ff == cic_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == cic_pkg::ST_RESP) && rmw_ph_ff;

   always_comb begin
      state_in = state_ff;
      rmw_ph_in = rmw_ph_ff;
      cmd = '0;
      case (state_ff)
         cic_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = cic_pkg::ST_IDLE;
         end
         cic_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cic_pkg::ST_SCALE;
            end
         end
         cic_pkg::ST_SCALE: begin
            if (status.is_read) begin
               cmd.rd = 1'b1;
               rmw_ph_in = 1'b0;
               state_in = cic_pkg::ST_RESP;
            end else begin
               cmd.scale = 1'b1;
               state_in = cic_pkg::ST_SPLIT;
            end
         end
         cic_pkg::ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in = cic_pkg::ST_W1;
         end
         cic_pkg::ST_W1: begin
            cmd.wmul = 1'b1; cmd.wstep = 2'd0; state_in = cic_pkg::ST_W2;
         end
         cic_pkg::ST_W2: begin
            cmd.wmul = 1'b1; cmd.wstep = 2'd1; state_in = cic_pkg::ST_W3;
         end
         cic_pkg::ST_W3: begin
            cmd.wmul = 1'b1; cmd.wstep = 2'd2;
            rmw_ph_in = 1'b0;
            state_in = cic_pkg::ST_RMW;
         end
         cic_pkg::ST_RMW: begin
            // read one corner, then write it back, so neighbouring corners never race
            if (!rmw_ph_ff) begin
               cmd.rd = 1'b1;
               rmw_ph_in = 1'b1;
            end else begin
               rmw_ph_in = 1'b0;
               cmd.corner_next = 1'b1;
               if (status.last_corner) state_in = cic_pkg::ST_IDLE;
            end
         end
         cic_pkg::ST_RESP: begin
            // first cycle: memory clears during write-back; hold until transfer
            rmw_ph_in = 1'b1;
            if (rmw_ph_ff && rsp_ready) begin
               rmw_ph_in = 1'b0;
               state_in = cic_pkg::ST_IDLE;
            end
         end
         default: state_in = cic_pkg::ST_IDLE;
      endcase
   end

   `CIC_ASSERT(a_onehot, clock, reset, $onehot(state_ff))
   `CIC_ASSERT(a_ready_excl, clock, reset, !(req_ready && rsp_valid))
   `CIC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid)
   `CIC_ASSERT(a_no_accept_clear, clock, reset, (state_ff == cic_pkg::ST_CLEAR) |-> !req_ready)
endmodule
`default_nettype wire

FILE: rtl/cloud_in_cell_deposit_core.sv
// Top level of the cloud-in-cell deposit core: registers, controller, datapath.
// Depends on cic_pkg, cic_control and cic_datapath.
//
//  Channel | Direction | Ports
//  req     | in        | req_valid/ready, mode, pos_x/y/z, read_index
//  rsp     | out       | rsp_valid/ready, cell_index, cell_value
//  csr     | in        | csr_valid/ready, csr_index, csr_wdata
//
// A deposit runs scale, split, three weight steps, then eight corner
// read-modify-writes of the single-port grid memory, each a read then a write.
// A read holds rsp_valid until rsp_ready; the cell clears on the way.
// After reset a clearing pass zeroes all GRID^3 cells before req_ready rises.
`default_nettype none
module cloud_in_cell_deposit_core #(
   parameter int unsigned GRID = 64,
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output      logic req_ready,
   input  wire logic req_mode,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [17:0] req_read_index,
   output      logic rsp_valid,
   input  wire logic rsp_ready,
   output      logic [17:0] rsp_cell_index,
   output      logic [31:0] rsp_cell_value,
   input  wire logic csr_valid,
   output      logic csr_ready,
   input  wire logic csr_index,
   input  wire logic [31:0] csr_wdata
);
   logic [31:0] inv_cell_size_ff, particle_weight_ff;
   cic_pkg::cmd_type cmd;
   cic_pkg::status_type status;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_cell_size_ff   <= 32'(1) << FRAC_BITS;
         particle_weight_ff <= 32'(1) << FRAC_BITS;
      end else if (csr_valid) begin
         if (csr_index == cic_pkg::CsrInvCellSize) inv_cell_size_ff <= csr_wdata;
         else particle_weight_ff <= csr_wdata;
      end
   end

   cic_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   cic_datapath #(.GRID(GRID), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_mode, .req_pos_x, .req_pos_y, .req_pos_z, .req_read_index,
      .inv_cell_size(inv_cell_size_ff), .particle_weight(particle_weight_ff),
      .rsp_cell_index, .rsp_cell_value
   );
endmodule
`default_nettype wire
